// ----- hdl/dequantize_q4_block_macros.svh -----
// ----------------------------------------------------------------------------
// dequantize_q4_block assertion macros
// shared concurrent assertion forms, clocked on clk_i and idle in reset
// ----------------------------------------------------------------------------
`ifndef DEQUANTIZE_Q4_BLOCK_MACROS_SVH
`define DEQUANTIZE_Q4_BLOCK_MACROS_SVH

// same-cycle implication
`define DQ4_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dq4 assertion failed");

// next-cycle implication
`define DQ4_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dq4 assertion failed");

`endif

// ----- hdl/dq4_pkg.sv -----
// ----------------------------------------------------------------------------
// dq4_pkg
// constants and types shared by the q4 block dequantizer
// ----------------------------------------------------------------------------
package dq4_pkg;

  localparam int unsigned BlockBytes   = 144;
  localparam int unsigned PayloadStart = 16;
  localparam int unsigned MagWidth     = 45;
  localparam logic [31:0] CanonNan     = 32'h7FC0_0000;
  localparam logic [30:0] InfBits      = 31'h7F80_0000;
  // single exponent of a fixed-point lsb of 2^-24: 127 - 24
  localparam logic [7:0]  ExpBase      = 8'd103;

  // exact difference of one nibble result, before rounding to single
  typedef struct packed {
    logic                special;
    logic [31:0]         special_bits;
    logic                sign;
    logic [MagWidth-1:0] mag;
  } dq4_diff_t;

endpackage

// ----- hdl/dequantize_q4_block.sv -----
// ----------------------------------------------------------------------------
// dequantize_q4_block
// q4 block dequantizer: 144-byte blocks in, 256 fp32 weights out per block
// ----------------------------------------------------------------------------
// Bytes 0-3 of each block load the half-precision scale and offset, bytes
// 4-15 are dropped, and each of bytes 16-143 gives two weights (low nibble at
// element i, high nibble at element 128+i), computed as nibble*scale - offset
// in single precision with round to nearest even; every NaN leaves as
// 0x7FC00000. A payload byte holds off the next byte until its high-nibble
// result moves on, since its two results share one fixed-point datapath and
// the result port, one per cycle while the output is not stalled. The
// low-nibble result of a byte passes the byte register, then the difference
// register, then the output register, and the high-nibble result follows it.
module dequantize_q4_block (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] weight_value, [39:32] element_index
  output logic        m_axis_tlast    // last_of_block
);
  import dq4_pkg::*;

  `include "dequantize_q4_block_macros.svh"

  logic [7:0]  pos_q, pos_d, pos_eff;
  logic [15:0] scale_q, offset_q;
  logic        s_acc, advance, payload;

  // item register
  logic        item_valid_q;
  logic        item_hi_q;
  logic [7:0]  item_byte_q;
  logic [6:0]  item_idx_q;

  // difference register
  logic        a_valid_q;
  dq4_diff_t   a_diff_q, a_diff_d;
  logic [7:0]  a_index_q;
  logic        a_last_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_bits_q, out_bits_d;
  logic [7:0]  out_index_q;
  logic        out_last_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !item_valid_q || (advance && item_hi_q);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign pos_eff       = (pos_q >= 8'(BlockBytes)) ? 8'd0 : pos_q;
  assign payload       = pos_eff >= 8'(PayloadStart);
  assign pos_d         = (pos_eff == 8'(BlockBytes - 1)) ? 8'd0 : pos_eff + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      scale_q  <= '0;
      offset_q <= '0;
    end else if (s_acc) begin
      pos_q <= pos_d;
      case (pos_eff)
        8'd0:    scale_q[7:0]   <= s_axis_tdata;
        8'd1:    scale_q[15:8]  <= s_axis_tdata;
        8'd2:    offset_q[7:0]  <= s_axis_tdata;
        8'd3:    offset_q[15:8] <= s_axis_tdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      item_hi_q    <= 1'b0;
    end else begin
      if (advance && item_valid_q) begin
        if (item_hi_q) item_valid_q <= 1'b0;
        else           item_hi_q    <= 1'b1;
      end
      if (s_acc && payload) begin
        item_valid_q <= 1'b1;
        item_hi_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && payload) begin
      item_byte_q <= s_axis_tdata;
      item_idx_q  <= 7'(pos_eff - 8'(PayloadStart));
    end
  end

  // ---- nibble * scale - offset, exact in fixed point with lsb 2^-24
  logic [3:0]  nib;
  logic [4:0]  ed, em;
  logic [9:0]  fd, fm;
  logic        sd, sm;
  logic        dnan, dinf, mnan, minf;
  logic [10:0] sigd, sigm;
  logic [4:0]  shd, shm;
  logic [14:0] pq;
  logic [43:0] pmag;
  logic [39:0] mmag;
  logic signed [45:0] pval, mval, dval;

  assign nib  = item_hi_q ? item_byte_q[7:4] : item_byte_q[3:0];
  assign sd   = scale_q[15];
  assign ed   = scale_q[14:10];
  assign fd   = scale_q[9:0];
  assign sm   = offset_q[15];
  assign em   = offset_q[14:10];
  assign fm   = offset_q[9:0];
  assign dnan = (ed == 5'h1F) && (fd != '0);
  assign dinf = (ed == 5'h1F) && (fd == '0);
  assign mnan = (em == 5'h1F) && (fm != '0);
  assign minf = (em == 5'h1F) && (fm == '0);
  assign sigd = (ed == '0) ? {1'b0, fd} : {1'b1, fd};
  assign sigm = (em == '0) ? {1'b0, fm} : {1'b1, fm};
  assign shd  = (ed == '0) ? 5'd0 : ed - 5'd1;
  assign shm  = (em == '0) ? 5'd0 : em - 5'd1;
  assign pq   = 15'(nib) * 15'(sigd);
  assign pmag = 44'(pq) << shd;
  assign mmag = 40'(sigm) << shm;
  assign pval = sd ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag});
  assign mval = sm ? -$signed({6'd0, mmag}) : $signed({6'd0, mmag});
  assign dval = pval - mval;

  always_comb begin
    a_diff_d.special      = dnan || mnan || dinf || minf;
    a_diff_d.special_bits = CanonNan;
    a_diff_d.sign         = dval[45];
    a_diff_d.mag          = dval[45] ? 45'(-dval) : dval[44:0];
    if (dnan || mnan) begin
      a_diff_d.special_bits = CanonNan;
    end else if (dinf) begin
      // inf * 0 and inf - inf of like sign are invalid
      if (nib == '0 || (minf && (sd == sm))) a_diff_d.special_bits = CanonNan;
      else a_diff_d.special_bits = {sd, InfBits};
    end else if (minf) begin
      a_diff_d.special_bits = {!sm, InfBits};
    end
    // exact zero: only -0 minus +0 keeps a negative sign
    if (dval == '0) begin
      a_diff_d.sign = (pmag == '0) && (mmag == '0) && sd && !sm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q   <= item_valid_q;
      out_valid_q <= a_valid_q;
    end
  end

  dq4_round u_round (
    .diff_i (a_diff_q),
    .bits_o (out_bits_d)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_diff_q    <= a_diff_d;
      a_index_q   <= {item_hi_q, item_idx_q};
      a_last_q    <= item_hi_q && (item_idx_q == 7'h7F);
      out_bits_q  <= out_bits_d;
      out_index_q <= a_index_q;
      out_last_q  <= a_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_index_q, out_bits_q};
  assign m_axis_tlast  = out_last_q;

  `DQ4_ASSERT_IMP(a_pos_range, 1'b1, pos_q < 8'(BlockBytes))
  `DQ4_ASSERT_IMP(a_last_index, out_valid_q && out_last_q, out_index_q == 8'hFF)
  `DQ4_ASSERT_NXT(a_payload_held, s_acc && payload, item_valid_q && !item_hi_q)

endmodule

// ----- hdl/dq4_round.sv -----
// ----------------------------------------------------------------------------
// dq4_round
// turns an exact fixed-point difference (lsb 2^-24) into a single-precision
// bit pattern, round to nearest even
// ----------------------------------------------------------------------------
module dq4_round (
  input  dq4_pkg::dq4_diff_t diff_i,
  output logic [31:0]        bits_o
);
  import dq4_pkg::*;

  logic [5:0]          lead;
  logic [5:0]          shamt;
  logic [MagWidth-1:0] norm;
  logic [22:0]         mant;
  logic                guard;
  logic                sticky;
  logic                rnd;
  logic [7:0]          expo;
  logic [30:0]         body;

  always_comb begin
    lead = '0;
    for (int i = 0; i < MagWidth; i++) begin
      if (diff_i.mag[i]) lead = 6'(i);
    end
  end

  assign shamt  = 6'(MagWidth - 1) - lead;
  assign norm   = diff_i.mag << shamt;
  assign mant   = norm[MagWidth-2 -: 23];
  assign guard  = norm[MagWidth-25];
  assign sticky = |norm[MagWidth-26:0];
  assign rnd    = guard & (sticky | mant[0]);
  assign expo   = 8'(lead) + ExpBase;
  // a rounding carry out of the mantissa bumps the exponent
  assign body   = {expo, mant} + 31'(rnd);

  always_comb begin
    if (diff_i.special) begin
      bits_o = diff_i.special_bits;
    end else if (diff_i.mag == '0) begin
      bits_o = {diff_i.sign, 31'd0};
    end else begin
      bits_o = {diff_i.sign, body};
    end
  end

endmodule

// ----- sim/dq4_checker.sv -----
// ----------------------------------------------------------------------------
// dq4_checker
// watches both streams of the q4 block dequantizer, predicts the fp32 weights
// of every accepted payload byte and compares them with what leaves the block
// ----------------------------------------------------------------------------
module dq4_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);
  import dq4_pkg::*;

  typedef struct {
    logic [31:0] weight;
    logic [7:0]  index;
    logic        last;
  } weight_t;

  weight_t     weights_due[$];
  int unsigned byte_pos;
  logic [15:0] scale_h;
  logic [15:0] offset_h;

  // widen a half to a double by bit fields
  function automatic real half_to_real(logic [15:0] h);
    logic [63:0] b;
    int          e;
    logic [9:0]  man;
    e   = h[14:10];
    man = h[9:0];
    b   = '0;
    b[63] = h[15];
    if (e == 31) begin
      b[62:52] = 11'h7FF;
      b[51:42] = man;
    end else if (e == 0 && man != 0) begin
      e = 1;
      while (!man[9]) begin
        man = man << 1;
        e--;
      end
      man      = man << 1;
      b[62:52] = 11'(e - 15 + 1023 - 1);
      b[51:42] = man;
    end else if (e != 0) begin
      b[62:52] = 11'(e - 15 + 1023);
      b[51:42] = man;
    end
    return $bitstoreal(b);
  endfunction

  // product is exact, difference is exact in double; one rounding to single
  function automatic logic [31:0] dequant(int unsigned q, real d, real m);
    real         diff;
    logic [63:0] b;
    logic [24:0] mm;
    int          fe;
    diff = (real'(q) * d) - m;
    b    = $realtobits(diff);
    if (b[62:52] == 11'h7FF) begin
      if (b[51:0] != 0) return CanonNan;
      return {b[63], 8'hFF, 23'h0};
    end
    if (b[62:52] == 0) return {b[63], 31'h0};
    fe = int'(b[62:52]) - 1023 + 127;
    mm = {2'b01, b[51:29]};
    if (b[28] && ((|b[27:0]) || b[29])) mm = mm + 1;
    if (mm[24]) begin
      mm = mm >> 1;
      fe++;
    end
    return {b[63], 8'(fe), mm[22:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    weight_t     w;
    weight_t     want;
    real         d;
    real         m;
    int unsigned i;
    if (!rst_ni) begin
      byte_pos     <= 0;
      scale_h      <= '0;
      offset_h     <= '0;
      fail_count_o <= 0;
      pending_o    <= 0;
      weights_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (weights_due.size() == 0) begin
          $error("unexpected weight 0x%08h index %0d", m_axis_tdata[31:0],
                 m_axis_tdata[39:32]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = weights_due.pop_front();
          if (m_axis_tdata[31:0] !== want.weight ||
              m_axis_tdata[39:32] !== want.index || m_axis_tlast !== want.last)
            fail_count_o <= fail_count_o + 1;
          if (m_axis_tdata[31:0] !== want.weight)
            $error("weight_value: expected 0x%08h, got 0x%08h", want.weight,
                   m_axis_tdata[31:0]);
          if (m_axis_tdata[39:32] !== want.index)
            $error("element_index: expected %0d, got %0d", want.index,
                   m_axis_tdata[39:32]);
          if (m_axis_tlast !== want.last)
            $error("last_of_block: expected %0b, got %0b", want.last,
                   m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (byte_pos)
          0: scale_h[7:0]    <= s_axis_tdata;
          1: scale_h[15:8]   <= s_axis_tdata;
          2: offset_h[7:0]   <= s_axis_tdata;
          3: offset_h[15:8]  <= s_axis_tdata;
          default: begin
            if (byte_pos >= PayloadStart) begin
              i = byte_pos - PayloadStart;
              d = half_to_real(scale_h);
              m = half_to_real(offset_h);
              w.weight = dequant(s_axis_tdata[3:0], d, m);
              w.index  = 8'(i);
              w.last   = 1'b0;
              weights_due.push_back(w);
              w.weight = dequant(s_axis_tdata[7:4], d, m);
              w.index  = 8'(128 + i);
              w.last   = (byte_pos == BlockBytes - 1);
              weights_due.push_back(w);
            end
          end
        endcase
        byte_pos <= (byte_pos + 1 >= BlockBytes) ? 0 : byte_pos + 1;
      end
      pending_o <= weights_due.size();
    end
  end

endmodule

// ----- sim/tb_dequantize_q4_block.sv -----
// ----------------------------------------------------------------------------
// tb_dequantize_q4_block
// streams whole 144-byte blocks with special scales and offsets under varied
// backpressure; the checker predicts and compares every weight
// ----------------------------------------------------------------------------
module tb_dequantize_q4_block;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] raw_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] weight_value, [39:32] element_index
  logic        m_axis_tlast;   // last_of_block
  logic        byte_taken;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_go;

  // interesting half values: zeros, subnormals, normals, infinities, nans
  logic [15:0] halves [14] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400,
                               16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7E00,
                               16'h7C01, 16'h3C00, 16'hBC00, 16'h3555};

  dequantize_q4_block dut (.*);

  dq4_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) byte_taken <= s_axis_tvalid && s_axis_tready;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_used;
    hold_left     = 0;
    hold_used     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_used) begin
        hold_left = 400;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(negedge clk_i); while (!byte_taken);
  endtask

  task automatic send_block(logic [15:0] scale, logic [15:0] offset, bit directed);
    logic [7:0] corner [6] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h5A, 8'hA5};
    send_byte(scale[7:0]);
    send_byte(scale[15:8]);
    send_byte(offset[7:0]);
    send_byte(offset[15:8]);
    for (int k = 4; k < 144; k++) begin
      if (directed && k >= 16 && k < 22) send_byte(corner[k - 16]);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  function automatic logic [15:0] pick_half();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return halves[$urandom_range(13)];
  endfunction

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_go       = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 69;
    rst_ni        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_block(16'h3C00, 16'h3C00, 1'b1);
    send_block(16'h7C00, 16'h0000, 1'b0);   // inf times zero nibble
    drain();

    send_idle_pct = 69;
    recv_idle_pct = 18;
    send_block(16'h7C00, 16'h7C00, 1'b0);   // inf minus inf
    send_block(pick_half(), pick_half(), 1'b0);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    send_block(pick_half(), pick_half(), 1'b0);
    hold_go = 1'b0;
    drain();

    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
